// ===== hw/rtl/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
`default_nettype none

package mexp_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int REG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_EXP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_EXP = 2'd2;

  localparam logic [REG_W-1:0] MODULUS_RST     = 32'd4982;
  localparam logic [REG_W-1:0] PUBLIC_EXP_RST  = 32'd1;
  localparam logic [REG_W-1:0] PRIVATE_EXP_RST = 32'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EXP,
    ST_MUL_ADD,
    ST_MUL_DBL,
    ST_DONE
  } mexp_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/modular_exponentiation.sv =====
// Modular exponentiation top level: square-and-multiply on one shared add-mod unit.
//
// Input words on s_*: s_tdata carries base_value, s_tuser carries mode
// (0 selects the public exponent, 1 the private exponent). Each word gives one
// output word on m_*: m_tdata = base_value ^ exponent mod modulus.
// Registers are written on cfg_* (index 0 modulus, 1 public exponent,
// 2 private exponent, others ignored); the user is to write them only while the
// block is idle, which the block does not enforce. One word is in flight at a
// time; s_tready is high only while idle. All arithmetic runs through a single
// add/compare/subtract unit, one use per cycle. When the modulus or exponent is
// zero the block goes straight to the result; otherwise it reduces the base one
// bit at a time, then for each exponent bit up to its highest set bit does one
// square plus one multiply when the bit is set, each multiply an add and a double
// step per multiplier bit up to its highest set bit plus a closing step.
// The result sits in an output register; if m_tready is low the block waits
// before loading a new result but the previous one is never lost.
// Reset (synchronous, rst high) returns registers to their defaults
// (modulus 4982, both exponents 1) and drops m_tvalid.
`default_nettype none

module modular_exponentiation #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [31:0]                    s_tdata,   // [31:0] base_value
  input  wire logic                           s_tuser,   // [0] mode
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [31:0]                         m_tdata,   // [31:0] result_value
  input  wire logic                           cfg_we,
  input  wire logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mexp_pkg::REG_W-1:0]     cfg_data
);
  import mexp_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(DATA_WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(DATA_WIDTH - 1);

  logic [REG_W-1:0] modulus;
  logic [REG_W-1:0] public_exponent;
  logic [REG_W-1:0] private_exponent;

  mexp_state_t state, state_next;

  logic [W-1:0]  m_r;
  logic [W-1:0]  e_r;
  logic [W-1:0]  base_r;
  logic [W-1:0]  acc;
  logic [W-1:0]  ma;
  logic [W-1:0]  mb;
  logic [W-1:0]  macc;
  logic [CW-1:0] cnt;
  logic          mul_sq;

  logic [W+31:0] base_wide, mod_wide, exp_wide, out_wide;
  logic [W-1:0]  base_sel, mod_sel, exp_sel;

  logic [W-1:0]  unit_x, unit_y, unit_out;
  logic          unit_cin;
  logic [W:0]    unit_sum, unit_diff;

  logic          accept;
  logic          load_out;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= MODULUS_RST;
      public_exponent  <= PUBLIC_EXP_RST;
      private_exponent <= PRIVATE_EXP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODULUS:     modulus          <= cfg_data;
        CFG_PUBLIC_EXP:  public_exponent  <= cfg_data;
        CFG_PRIVATE_EXP: private_exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  // width adaptation to DATA_WIDTH
  always_comb begin
    base_wide = {{W{1'b0}}, s_tdata};
    mod_wide  = {{W{1'b0}}, modulus};
    exp_wide  = {{W{1'b0}}, (s_tuser ? private_exponent : public_exponent)};
    out_wide  = {32'd0, acc};
    base_sel  = base_wide[W-1:0];
    mod_sel   = mod_wide[W-1:0];
    exp_sel   = exp_wide[W-1:0];
  end

  // shared add-mod unit: (x + y + cin) reduced once by m
  always_comb begin
    unique case (state)
      ST_REDUCE: begin
        unit_x   = macc;
        unit_y   = macc;
        unit_cin = base_r[W-1];
      end
      ST_MUL_DBL: begin
        unit_x   = ma;
        unit_y   = ma;
        unit_cin = 1'b0;
      end
      default: begin
        unit_x   = macc;
        unit_y   = ma;
        unit_cin = 1'b0;
      end
    endcase
    unit_sum  = {1'b0, unit_x} + {1'b0, unit_y} + {{W{1'b0}}, unit_cin};
    unit_diff = unit_sum - {1'b0, m_r};
    unit_out  = (unit_sum >= {1'b0, m_r}) ? unit_diff[W-1:0] : unit_sum[W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if ((mod_sel == '0) || (exp_sel == '0)) state_next = ST_DONE;
          else                                     state_next = ST_REDUCE;
        end
      end
      ST_REDUCE:  if (cnt == '0) state_next = ST_EXP;
      ST_EXP:     state_next = (e_r == '0) ? ST_DONE : ST_MUL_ADD;
      ST_MUL_ADD: begin
        if (mb != '0)  state_next = ST_MUL_DBL;
        else if (mul_sq) state_next = ST_EXP;
        else             state_next = ST_MUL_ADD;
      end
      ST_MUL_DBL: state_next = ST_MUL_ADD;
      ST_DONE:    if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_tready = (state == ST_IDLE);
    accept   = s_tvalid && s_tready;
    load_out = (state == ST_DONE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (load_out) m_tdata <= out_wide[31:0];
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          m_r    <= mod_sel;
          e_r    <= exp_sel;
          base_r <= base_sel;
          acc    <= (mod_sel == '0) ? '0 : W'(1);
          macc   <= '0;
          cnt    <= CNT_LAST;
        end
      end
      ST_REDUCE: begin
        macc <= unit_out;
        cnt  <= cnt - CW'(1);
        if (cnt == '0) begin
          base_r <= unit_out;
          acc    <= (m_r == W'(1)) ? '0 : W'(1);
        end else begin
          base_r <= {base_r[W-2:0], 1'b0};
        end
      end
      ST_EXP: begin
        ma     <= base_r;
        macc   <= '0;
        mul_sq <= !e_r[0];
        mb     <= e_r[0] ? acc : base_r;
      end
      ST_MUL_ADD: begin
        if (mb == '0) begin
          if (mul_sq) begin
            base_r <= macc;
            e_r    <= e_r >> 1;
          end else begin
            acc    <= macc;
            mul_sq <= 1'b1;
            ma     <= base_r;
            mb     <= base_r;
            macc   <= '0;
          end
        end else if (mb[0]) begin
          macc <= unit_out;
        end
      end
      ST_MUL_DBL: begin
        ma <= unit_out;
        mb <= mb >> 1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mexp_checker.sv =====
// Port-level checker for the modular exponentiation block, bound to the top level.
`default_nettype none

module mexp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while busy");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared one cycle after accept");

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result loaded while idle");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
